// ===== design/msc_pkg.sv =====
// Shared types and constants for the MIPS subset core.
`timescale 1ns / 1ps
package msc_pkg;

  localparam int XLEN      = 32;
  localparam int REG_CNT   = 32;
  localparam int REG_IDX_W = 5;
  localparam int PLEN_W    = 30;
  localparam int CFG_IDX_W = 2;
  localparam int MD_STEPS  = 32;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PROG_LEN   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INIT_TWO   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INIT_THREE = 2'd2;

  localparam logic [REG_IDX_W-1:0] REG_TWO   = 5'd2;
  localparam logic [REG_IDX_W-1:0] REG_THREE = 5'd3;
  localparam logic [REG_IDX_W-1:0] REG_LINK  = 5'd31;

  // opcode field
  localparam logic [5:0] OP_SPECIAL = 6'h00;
  localparam logic [5:0] OP_BEQ     = 6'h04;
  localparam logic [5:0] OP_BNE     = 6'h05;
  localparam logic [5:0] OP_LW      = 6'h2A;
  localparam logic [5:0] OP_SW      = 6'h2B;

  // low 11 bits
  localparam logic [10:0] FN_ADD  = 11'h020;
  localparam logic [10:0] FN_SUB  = 11'h022;
  localparam logic [10:0] FN_MFHI = 11'h010;
  localparam logic [10:0] FN_MFLO = 11'h012;
  localparam logic [10:0] FN_LIS  = 11'h014;
  localparam logic [10:0] FN_SLT  = 11'h02A;
  localparam logic [10:0] FN_SLTU = 11'h02B;

  // low 16 bits
  localparam logic [15:0] FN_MULT  = 16'h0018;
  localparam logic [15:0] FN_MULTU = 16'h0019;
  localparam logic [15:0] FN_DIV   = 16'h001A;
  localparam logic [15:0] FN_DIVU  = 16'h001B;

  // low 21 bits
  localparam logic [20:0] FN_JR   = 21'h000008;
  localparam logic [20:0] FN_JALR = 21'h000009;

  localparam logic [31:0] SIGN_BIT = 32'h8000_0000;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DEC,
    ST_AMOD,
    ST_MEM,
    ST_LOAD,
    ST_MD,
    ST_OUT
  } core_state_t;

  typedef enum logic [1:0] {
    MD_IDLE,
    MD_RUN,
    MD_FIX
  } md_state_t;

  typedef struct packed {
    logic start;
    logic is_div;
    logic is_signed;
  } md_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] hi;
    logic [31:0] lo;
  } md_rsp_t;

endpackage

// ===== design/msc_chan_if.sv =====
// Valid/ready channel interfaces for instruction input and step results.
`timescale 1ns / 1ps
interface msc_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] instr_word;

  modport source (output valid, output instr_word, input ready);
  modport sink (input valid, input instr_word, output ready);
endinterface

interface msc_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] next_pc;
  logic        halted;
  logic        reg_write;
  logic [4:0]  write_index;
  logic [31:0] write_value;
  logic [31:0] hi_value;
  logic [31:0] lo_value;
  logic        mem_write;
  logic [7:0]  mem_index;
  logic [31:0] mem_value;

  modport source (output valid, output next_pc, output halted, output reg_write,
                  output write_index, output write_value, output hi_value,
                  output lo_value, output mem_write, output mem_index,
                  output mem_value, input ready);
  modport sink (input valid, input next_pc, input halted, input reg_write,
                input write_index, input write_value, input hi_value,
                input lo_value, input mem_write, input mem_index,
                input mem_value, output ready);
endinterface

// ===== design/msc_regfile.sv =====
// 32 x 32 register file, two registered read ports, valid bits for reset.
`timescale 1ns / 1ps
module msc_regfile
  import msc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [REG_IDX_W-1:0] raddr_a,
  input  logic [REG_IDX_W-1:0] raddr_b,
  output logic [XLEN-1:0]      rdata_a,
  output logic [XLEN-1:0]      rdata_b,
  input  logic                 we,
  input  logic [REG_IDX_W-1:0] waddr,
  input  logic [XLEN-1:0]      wdata
);

  logic [XLEN-1:0]    mem [REG_CNT];
  logic [REG_CNT-1:0] vld_r;
  logic [XLEN-1:0]    rdata_a_r;
  logic [XLEN-1:0]    rdata_b_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (we && waddr != '0) begin
      vld_r[waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (we && waddr != '0) begin
      mem[waddr] <= wdata;
    end
    rdata_a_r <= vld_r[raddr_a] ? mem[raddr_a] : '0;
    rdata_b_r <= vld_r[raddr_b] ? mem[raddr_b] : '0;
  end

  assign rdata_a = rdata_a_r;
  assign rdata_b = rdata_b_r;

endmodule

// ===== design/msc_muldiv.sv =====
// Iterative multiply / divide unit, one bit per cycle on a shared 34-bit adder.
`timescale 1ns / 1ps
module msc_muldiv
  import msc_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  md_req_t         req,
  input  logic [XLEN-1:0] op_a,
  input  logic [XLEN-1:0] op_b,
  output md_rsp_t         rsp
);

  md_state_t    state_r, state_nxt;
  logic [4:0]   cnt_r, cnt_nxt;
  logic [63:0]  acc_r, acc_nxt;
  logic [31:0]  m_r, m_nxt;
  logic         div_r, div_nxt;
  logic         neg_p_r, neg_p_nxt;
  logic         neg_r_r, neg_r_nxt;

  logic [32:0]  add_x;
  logic [32:0]  add_y;
  logic         add_inv;
  logic [33:0]  add_sum;
  logic [63:0]  prod_neg;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= MD_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r   <= acc_nxt;
    m_r     <= m_nxt;
    div_r   <= div_nxt;
    neg_p_r <= neg_p_nxt;
    neg_r_r <= neg_r_nxt;
  end

  // shared adder: multiply adds, divide subtracts
  always_comb begin
    if (div_r) begin
      add_x   = {acc_r[63:32], acc_r[31]};
      add_y   = ~{1'b0, m_r};
      add_inv = 1'b1;
    end else begin
      add_x   = {1'b0, acc_r[63:32]};
      add_y   = acc_r[0] ? {1'b0, m_r} : '0;
      add_inv = 1'b0;
    end
    add_sum = {1'b0, add_x} + {1'b0, add_y} + {33'd0, add_inv};
  end

  assign prod_neg = 64'd0 - acc_r;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    acc_nxt   = acc_r;
    m_nxt     = m_r;
    div_nxt   = div_r;
    neg_p_nxt = neg_p_r;
    neg_r_nxt = neg_r_r;
    rsp       = '0;
    unique case (state_r)
      MD_IDLE: begin
        if (req.start) begin
          acc_nxt   = {32'd0, (req.is_signed && op_a[31]) ? 32'd0 - op_a : op_a};
          m_nxt     = (req.is_signed && op_b[31]) ? 32'd0 - op_b : op_b;
          div_nxt   = req.is_div;
          neg_p_nxt = req.is_signed && (op_a[31] ^ op_b[31]);
          neg_r_nxt = req.is_signed && op_a[31];
          cnt_nxt   = '0;
          state_nxt = MD_RUN;
        end
      end
      MD_RUN: begin
        if (div_r) begin
          acc_nxt = add_sum[33] ? {add_sum[31:0], acc_r[30:0], 1'b1}
                                : {acc_r[62:0], 1'b0};
        end else begin
          acc_nxt = {add_sum[32:0], acc_r[31:1]};
        end
        cnt_nxt = cnt_r + 5'd1;
        if (cnt_r == 5'(MD_STEPS - 1)) begin
          state_nxt = MD_FIX;
        end
      end
      MD_FIX: begin
        rsp.done = 1'b1;
        if (div_r) begin
          rsp.lo = neg_p_r ? 32'd0 - acc_r[31:0] : acc_r[31:0];
          rsp.hi = neg_r_r ? 32'd0 - acc_r[63:32] : acc_r[63:32];
        end else begin
          rsp.lo = neg_p_r ? prod_neg[31:0] : acc_r[31:0];
          rsp.hi = neg_p_r ? prod_neg[63:32] : acc_r[63:32];
        end
        state_nxt = MD_IDLE;
      end
      default: begin
        state_nxt = MD_IDLE;
      end
    endcase
  end

endmodule

// ===== design/mips_subset_core_unit.sv =====
// Top level of the MIPS subset core: sequencer, data memory and outputs.
`timescale 1ns / 1ps
// Usage:
//  in_chan carries one instruction word per transaction (or the literal
//  after lis); out_chan returns exactly one result transaction per input.
//  in_chan.ready is high only while the core is idle; one word is worked
//  on at a time and its result is held on out_chan until taken.
//  Path from accept to out_chan.valid:
//   plain ops, branches, jumps, lis, literal, halted: decode, output
//   sw: decode, memory, output; lw: decode, memory, load, output
//   (power-of-two DATA_WORDS); other sizes first reduce the word index on
//   the divider. mult/multu/div/divu: decode, bit-serial mul/div unit, output
//   (div by zero bypasses the unit: decode, output)
//  A new word is accepted only once the result has been taken.
//  Reset (rst_n low, synchronous): registers, hi/lo, pc and flags clear,
//  then a clearing pass zeroes the data memory, during which no word is
//  accepted. prog_len writes always land; init_reg_two/three writes load
//  register 2/3 unless the core writes the register file in that cycle.
//  A stalled receiver simply holds the core in its output state.
module mips_subset_core_unit
  import msc_pkg::*;
#(
  parameter int DATA_WORDS = 256
) (
  input  logic                 clk,
  input  logic                 rst_n,
  msc_in_if.sink               in_chan,
  msc_out_if.source            out_chan,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [XLEN-1:0]      cfg_wdata
);

  localparam int  AW   = $clog2(DATA_WORDS);
  localparam bit  POW2 = (DATA_WORDS & (DATA_WORDS - 1)) == 0;

  core_state_t          state_r, state_nxt;
  logic [31:0]          pc_r, pc_nxt;
  logic                 stop_r, stop_nxt;
  logic                 pend_r, pend_nxt;
  logic [4:0]           dest_r, dest_nxt;
  logic [31:0]          hi_r, hi_nxt;
  logic [31:0]          lo_r, lo_nxt;
  logic [PLEN_W-1:0]    plen_r;
  logic [AW-1:0]        clr_cnt_r, clr_cnt_nxt;
  logic [31:0]          instr_r, instr_nxt;
  logic [31:0]          b_r, b_nxt;
  logic [AW-1:0]        idx_r, idx_nxt;

  // result fields held for the output transaction
  logic                 o_rw_r, o_rw_nxt;
  logic [4:0]           o_widx_r, o_widx_nxt;
  logic [31:0]          o_wval_r, o_wval_nxt;
  logic                 o_mw_r, o_mw_nxt;
  logic [7:0]           o_midx_r, o_midx_nxt;
  logic [31:0]          o_mval_r, o_mval_nxt;

  logic [31:0]          rf_a, rf_b;
  logic                 rf_we;
  logic [REG_IDX_W-1:0] rf_widx;
  logic [31:0]          rf_wdata;
  logic                 core_we;
  logic [REG_IDX_W-1:0] core_widx;
  logic [31:0]          core_wdata;

  md_req_t              md_req;
  md_rsp_t              md_rsp;
  logic [31:0]          md_a, md_b;

  logic [31:0]          dmem [DATA_WORDS];
  logic [31:0]          dm_rdata_r;
  logic                 dm_we;
  logic [AW-1:0]        dm_waddr;
  logic [31:0]          dm_wdata;

  logic                 in_fire, out_fire;

  assign in_fire  = in_chan.valid && in_chan.ready;
  assign out_fire = out_chan.valid && out_chan.ready;

  msc_regfile u_rf (
    .clk     (clk),
    .rst_n   (rst_n),
    .raddr_a (in_chan.instr_word[25:21]),
    .raddr_b (in_chan.instr_word[20:16]),
    .rdata_a (rf_a),
    .rdata_b (rf_b),
    .we      (rf_we),
    .waddr   (rf_widx),
    .wdata   (rf_wdata)
  );

  msc_muldiv u_md (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (md_req),
    .op_a  (md_a),
    .op_b  (md_b),
    .rsp   (md_rsp)
  );

  // core writes win; the user must make config writes only while idle (not enforced here)
  always_comb begin
    rf_we    = core_we;
    rf_widx  = core_widx;
    rf_wdata = core_wdata;
    if (!core_we && cfg_we) begin
      if (cfg_index == CFG_INIT_TWO) begin
        rf_we   = 1'b1;
        rf_widx = REG_TWO;
        rf_wdata = cfg_wdata;
      end else if (cfg_index == CFG_INIT_THREE) begin
        rf_we   = 1'b1;
        rf_widx = REG_THREE;
        rf_wdata = cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      plen_r <= '0;
    end else if (cfg_we && cfg_index == CFG_PROG_LEN) begin
      plen_r <= cfg_wdata[PLEN_W-1:0];
    end
  end

  // data memory
  always_ff @(posedge clk) begin
    if (dm_we) begin
      dmem[dm_waddr] <= dm_wdata;
    end
    dm_rdata_r <= dmem[idx_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_CLEAR;
      pc_r      <= '0;
      stop_r    <= 1'b0;
      pend_r    <= 1'b0;
      dest_r    <= '0;
      hi_r      <= '0;
      lo_r      <= '0;
      clr_cnt_r <= '0;
    end else begin
      state_r   <= state_nxt;
      pc_r      <= pc_nxt;
      stop_r    <= stop_nxt;
      pend_r    <= pend_nxt;
      dest_r    <= dest_nxt;
      hi_r      <= hi_nxt;
      lo_r      <= lo_nxt;
      clr_cnt_r <= clr_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    instr_r  <= instr_nxt;
    b_r      <= b_nxt;
    idx_r    <= idx_nxt;
    o_rw_r   <= o_rw_nxt;
    o_widx_r <= o_widx_nxt;
    o_wval_r <= o_wval_nxt;
    o_mw_r   <= o_mw_nxt;
    o_midx_r <= o_midx_nxt;
    o_mval_r <= o_mval_nxt;
  end

  always_comb begin
    logic [5:0]  op;
    logic [10:0] fn11;
    logic [15:0] imm;
    logic [31:0] simm;
    logic [31:0] ea;
    logic [31:0] pc_t;
    logic [31:0] idx_ext;
    logic        upper0;
    logic        adv;
    logic        chk;
    logic        rw;
    logic [4:0]  widx;
    logic [31:0] wval;
    logic        stop_t;

    op      = instr_r[31:26];
    fn11    = instr_r[10:0];
    imm     = instr_r[15:0];
    simm    = {{16{imm[15]}}, imm};
    ea      = rf_a + simm;
    upper0  = instr_r[31:16] == 16'd0;
    idx_ext = 32'(idx_r);
    pc_t    = pc_r;
    adv     = 1'b1;
    chk     = 1'b1;
    rw      = 1'b0;
    widx    = '0;
    wval    = '0;
    stop_t  = stop_r;

    state_nxt   = state_r;
    pc_nxt      = pc_r;
    stop_nxt    = stop_r;
    pend_nxt    = pend_r;
    dest_nxt    = dest_r;
    hi_nxt      = hi_r;
    lo_nxt      = lo_r;
    clr_cnt_nxt = clr_cnt_r;
    instr_nxt   = instr_r;
    b_nxt       = b_r;
    idx_nxt     = idx_r;
    o_rw_nxt    = o_rw_r;
    o_widx_nxt  = o_widx_r;
    o_wval_nxt  = o_wval_r;
    o_mw_nxt    = o_mw_r;
    o_midx_nxt  = o_midx_r;
    o_mval_nxt  = o_mval_r;
    core_we     = 1'b0;
    core_widx   = '0;
    core_wdata  = '0;
    md_req      = '0;
    md_a        = rf_a;
    md_b        = rf_b;
    dm_we       = 1'b0;
    dm_waddr    = idx_r;
    dm_wdata    = b_r;

    unique case (state_r)
      ST_CLEAR: begin
        dm_we    = 1'b1;
        dm_waddr = clr_cnt_r;
        dm_wdata = '0;
        if (clr_cnt_r == AW'(DATA_WORDS - 1)) begin
          state_nxt = ST_IDLE;
        end else begin
          clr_cnt_nxt = clr_cnt_r + 1'b1;
        end
      end
      ST_IDLE: begin
        if (in_fire) begin
          instr_nxt = in_chan.instr_word;
          state_nxt = ST_DEC;
        end
      end
      ST_DEC: begin
        state_nxt  = ST_OUT;
        b_nxt      = rf_b;
        o_mw_nxt   = 1'b0;
        o_midx_nxt = '0;
        o_mval_nxt = '0;
        if (stop_r) begin
          adv = 1'b0;
          chk = 1'b0;
        end else if (pend_r) begin
          pend_nxt = 1'b0;
          if (dest_r != '0) begin
            rw   = 1'b1;
            widx = dest_r;
            wval = instr_r;
          end
        end else begin
          priority if (op == OP_SPECIAL && fn11 == FN_ADD) begin
            rw = 1'b1; widx = instr_r[15:11]; wval = rf_a + rf_b;
          end else if (op == OP_SPECIAL && fn11 == FN_SUB) begin
            rw = 1'b1; widx = instr_r[15:11]; wval = rf_a - rf_b;
          end else if (op == OP_SPECIAL && (imm == FN_MULT || imm == FN_MULTU)) begin
            md_req.start     = 1'b1;
            md_req.is_signed = imm == FN_MULT;
            state_nxt        = ST_MD;
          end else if (op == OP_SPECIAL && (imm == FN_DIV || imm == FN_DIVU)) begin
            if (rf_b == '0) begin
              lo_nxt = '1;
              hi_nxt = rf_a;
            end else begin
              md_req.start     = 1'b1;
              md_req.is_div    = 1'b1;
              md_req.is_signed = imm == FN_DIV;
              state_nxt        = ST_MD;
            end
          end else if (upper0 && fn11 == FN_MFHI) begin
            rw = 1'b1; widx = instr_r[15:11]; wval = hi_r;
          end else if (upper0 && fn11 == FN_MFLO) begin
            rw = 1'b1; widx = instr_r[15:11]; wval = lo_r;
          end else if (upper0 && fn11 == FN_LIS) begin
            pend_nxt = 1'b1;
            dest_nxt = instr_r[15:11];
            chk      = 1'b0;
          end else if (op == OP_LW || op == OP_SW) begin
            // word index = byte address / 4, modulo memory depth
            if (POW2) begin
              idx_nxt   = ea[AW+1:2];
              state_nxt = ST_MEM;
            end else begin
              md_req.start = 1'b1;
              md_req.is_div = 1'b1;
              md_a         = {2'b00, ea[31:2]};
              md_b         = 32'(DATA_WORDS);
              state_nxt    = ST_AMOD;
            end
          end else if (op == OP_SPECIAL && fn11 == FN_SLT) begin
            rw = 1'b1; widx = instr_r[15:11];
            wval = 32'((rf_a ^ SIGN_BIT) < (rf_b ^ SIGN_BIT));
          end else if (op == OP_SPECIAL && fn11 == FN_SLTU) begin
            rw = 1'b1; widx = instr_r[15:11];
            wval = 32'(rf_a < rf_b);
          end else if (op == OP_BEQ) begin
            if (rf_a == rf_b) pc_t = pc_r + simm;
          end else if (op == OP_BNE) begin
            if (rf_a != rf_b) pc_t = pc_r + simm;
          end else if (op == OP_SPECIAL && instr_r[20:0] == FN_JR) begin
            pc_t = {2'b00, rf_a[31:2]};
            adv  = 1'b0;
            if (rf_a[31:2] == 30'd0) begin
              stop_t = 1'b1;
              chk    = 1'b0;
            end
          end else if (op == OP_SPECIAL && instr_r[20:0] == FN_JALR) begin
            rw   = 1'b1;
            widx = REG_LINK;
            wval = {pc_r[29:0] + 30'd1, 2'b00};
            pc_t = {2'b00, rf_a[31:2]};
            adv  = 1'b0;
          end else begin
            // unknown word: no operation
          end
          if (rw && widx == '0) begin
            rw   = 1'b0;
            wval = '0;
          end
        end
        if (adv) pc_t = pc_t + 32'd1;
        if (chk && pc_t >= {2'b00, plen_r}) stop_t = 1'b1;
        pc_nxt     = pc_t;
        stop_nxt   = stop_t;
        core_we    = rw;
        core_widx  = widx;
        core_wdata = wval;
        o_rw_nxt   = rw;
        o_widx_nxt = widx;
        o_wval_nxt = wval;
      end
      ST_AMOD: begin
        if (md_rsp.done) begin
          idx_nxt   = md_rsp.hi[AW-1:0];
          state_nxt = ST_MEM;
        end
      end
      ST_MEM: begin
        if (op == OP_SW) begin
          dm_we      = 1'b1;
          o_mw_nxt   = 1'b1;
          o_midx_nxt = idx_ext[7:0];
          o_mval_nxt = b_r;
          state_nxt  = ST_OUT;
        end else begin
          state_nxt = ST_LOAD;
        end
      end
      ST_LOAD: begin
        o_widx_nxt = instr_r[20:16];
        if (instr_r[20:16] != '0) begin
          core_we    = 1'b1;
          core_widx  = instr_r[20:16];
          core_wdata = dm_rdata_r;
          o_rw_nxt   = 1'b1;
          o_wval_nxt = dm_rdata_r;
        end else begin
          o_rw_nxt   = 1'b0;
          o_wval_nxt = '0;
        end
        state_nxt = ST_OUT;
      end
      ST_MD: begin
        if (md_rsp.done) begin
          hi_nxt    = md_rsp.hi;
          lo_nxt    = md_rsp.lo;
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_fire) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign in_chan.ready        = state_r == ST_IDLE;
  assign out_chan.valid       = state_r == ST_OUT;
  assign out_chan.next_pc     = pc_r;
  assign out_chan.halted      = stop_r;
  assign out_chan.reg_write   = o_rw_r;
  assign out_chan.write_index = o_widx_r;
  assign out_chan.write_value = o_wval_r;
  assign out_chan.hi_value    = hi_r;
  assign out_chan.lo_value    = lo_r;
  assign out_chan.mem_write   = o_mw_r;
  assign out_chan.mem_index   = o_midx_r;
  assign out_chan.mem_value   = o_mval_r;

  // one item in flight: never accepting while a result is offered
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_chan.ready && out_chan.valid))
    else $error("input accepted while result pending");

  // halt is sticky until reset
  a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    stop_r |=> stop_r)
    else $error("halt flag dropped");

  // the shared unit is only launched from decode
  a_md_start: assert property (@(posedge clk) disable iff (!rst_n)
    md_req.start |-> state_r == ST_DEC)
    else $error("mul/div started outside decode");

  // register zero is never targeted
  a_no_r0_write: assert property (@(posedge clk) disable iff (!rst_n)
    rf_we |-> rf_widx != '0)
    else $error("write to register zero");

endmodule
